// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== design/artdmx_pkg.sv =====
package artdmx_pkg;

	localparam int unsigned CH_W      = 9;
	localparam int unsigned UNIV_W    = 15;
	localparam int unsigned START_W   = 9;
	localparam int unsigned STATUS_W  = 3;

	localparam int unsigned ID_LEN       = 7;
	localparam int unsigned ID_MIN_LAST  = 6;
	localparam int unsigned POS_OPC_LO   = 8;
	localparam int unsigned POS_OPC_HI   = 9;
	localparam int unsigned POS_UNIV_LO  = 14;
	localparam int unsigned POS_UNIV_HI  = 15;
	localparam int unsigned POS_LEN_HI   = 16;
	localparam int unsigned POS_LEN_LO   = 17;
	localparam int unsigned DATA_START   = 18;

	localparam logic [15:0] OP_DMX  = 16'h5000;
	localparam logic [15:0] OP_POLL = 16'h2000;

	typedef enum logic [0:0] {
		CFG_UNIVERSE = 1'b0,
		CFG_START    = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DMX_APPLIED  = 3'd0,
		ST_BAD_ID       = 3'd1,
		ST_POLL         = 3'd2,
		ST_OTHER_OP     = 3'd3,
		ST_UNIV_MISMATCH = 3'd4
	} status_t;

	typedef struct packed {
		logic            write_enable;
		logic [CH_W-1:0] channel_index;
		logic [7:0]      channel_value;
		logic            packet_done;
		status_t         packet_status;
	} result_t;

	function automatic logic [7:0] id_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h41;
			3'd1:    c = 8'h72;
			3'd2:    c = 8'h74;
			3'd3:    c = 8'h2D;
			3'd4:    c = 8'h4E;
			3'd5:    c = 8'h65;
			3'd6:    c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== design/artdmx_packet_receiver.sv =====
// Art-Net ArtDmx receiver.
// Feed the UDP payload of one packet as a stream of byte words on s_axis,
// tlast high on the final byte. Each accepted word yields exactly one result
// word on m_axis: a channel write (write_enable, channel_index, value) when
// the byte is DMX data for this node, and on the final byte tlast high with
// the packet status in tuser (0 applied, 1 bad id, 2 poll, 3 other opcode,
// 4 universe mismatch).
// Each accepted word passes one input stage register, then the parser and
// the result register. One word per cycle is sustained while m_axis_tready
// stays high; the parser state advances by one byte position per word, up
// to MAX_PACKET_BYTES.
// A stall on m_axis holds the result register and then the input stage, and
// s_axis_tready drops only when both are full.
// Write universe (index 0) and start_address (index 1) through the cfg port
// while the stream is idle; cfg_ready is always high.
// Reset restarts the packet state and clears both pipeline valids and the cfg registers.
module artdmx_packet_receiver #(
	parameter int unsigned LED_COUNT        = 170,
	parameter int unsigned MAX_PACKET_BYTES = 530
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] write_enable, [9:1] channel_index,
	                                    // [17:10] channel_value, [23:18] zero
	output logic        m_axis_tlast,   // packet_done
	output logic [2:0]  m_axis_tuser,   // [2:0] packet_status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int unsigned CAP = LED_COUNT * 3;

	logic                               valid_s1;
	logic [7:0]                         byte_s1;
	logic                               last_s1;
	logic                               advance;
	logic                               out_valid_q;
	artdmx_pkg::result_t                res_q;
	artdmx_pkg::result_t                res_n;
	logic [artdmx_pkg::UNIV_W-1:0]      universe_q;
	logic [artdmx_pkg::START_W-1:0]     start_q;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q <= '0;
			start_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (artdmx_pkg::cfg_reg_t'(cfg_index))
				artdmx_pkg::CFG_UNIVERSE: universe_q <= cfg_data;
				artdmx_pkg::CFG_START:    start_q    <= cfg_data[artdmx_pkg::START_W-1:0];
				default:                  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	artdmx_parse #(
		.LED_COUNT        (LED_COUNT),
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.packet_byte   (byte_s1),
		.last_byte     (last_s1),
		.universe      (universe_q),
		.start_address (start_q),
		.result        (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, res_q.channel_value, res_q.channel_index, res_q.write_enable};
	assign m_axis_tlast  = res_q.packet_done;
	assign m_axis_tuser  = res_q.packet_status;

	`ASSERT_PROP(a_write_in_range, clk, arst_n,
		(m_axis_tvalid && res_q.write_enable) |-> (32'(res_q.channel_index) < CAP),
		"channel index beyond LED channel count")
	`ASSERT_NEVER(a_status_without_done, clk, arst_n,
		m_axis_tvalid && !res_q.packet_done && (res_q.packet_status != artdmx_pkg::ST_DMX_APPLIED),
		"status set on a word that does not end the packet")
	`ASSERT_NEVER(a_idle_write_payload, clk, arst_n,
		m_axis_tvalid && !res_q.write_enable
			&& ((res_q.channel_index != '0) || (res_q.channel_value != '0)),
		"channel payload set without a write")
	`ASSERT_PROP(a_stage_moves, clk, arst_n,
		(valid_s1 && (!out_valid_q || m_axis_tready)) |=> out_valid_q,
		"input stage advanced without filling the result register")

endmodule

// ===== design/artdmx_parse.sv =====
module artdmx_parse #(
	parameter int unsigned LED_COUNT        = 170,
	parameter int unsigned MAX_PACKET_BYTES = 530
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [7:0]                          packet_byte,
	input  logic                                last_byte,
	input  logic [artdmx_pkg::UNIV_W-1:0]       universe,
	input  logic [artdmx_pkg::START_W-1:0]      start_address,
	output artdmx_pkg::result_t                 result
);

	localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned CAP   = LED_COUNT * 3;

	logic [POS_W-1:0]            pos_q, pos_n;
	logic                        id_ok_q, id_ok_n;
	logic [15:0]                 opc_q, opc_n;
	logic [15:0]                 univ_q, univ_n;
	logic [15:0]                 len_q, len_n;
	logic [artdmx_pkg::CH_W-1:0] cw_q, cw_n;

	logic        in_buf;
	logic        dmx_for_us;
	logic        room;
	logic [15:0] data_first;
	logic [15:0] cw_plus_start;

	assign in_buf        = pos_q < POS_W'(MAX_PACKET_BYTES);
	assign dmx_for_us    = id_ok_q && (opc_q == artdmx_pkg::OP_DMX)
		&& (univ_q[artdmx_pkg::UNIV_W-1:0] == universe);
	assign data_first    = 16'(artdmx_pkg::DATA_START) + 16'(start_address);
	assign cw_plus_start = 16'(cw_q) + 16'(start_address);
	assign room          = (cw_q < artdmx_pkg::CH_W'(CAP)) && (cw_plus_start < len_q);

	always_comb begin
		pos_n  = pos_q;
		id_ok_n = id_ok_q;
		opc_n  = opc_q;
		univ_n = univ_q;
		len_n  = len_q;
		cw_n   = cw_q;
		result = '0;
		if (in_buf) begin
			if (pos_q < POS_W'(artdmx_pkg::ID_LEN)) begin
				if (packet_byte != artdmx_pkg::id_char(pos_q[2:0])) begin
					id_ok_n = 1'b0;
				end
			end else if (pos_q == POS_W'(artdmx_pkg::POS_OPC_LO)) begin
				opc_n[7:0] = packet_byte;
			end else if (pos_q == POS_W'(artdmx_pkg::POS_OPC_HI)) begin
				opc_n[15:8] = packet_byte;
			end else if (pos_q == POS_W'(artdmx_pkg::POS_UNIV_LO)) begin
				univ_n[7:0] = packet_byte;
			end else if (pos_q == POS_W'(artdmx_pkg::POS_UNIV_HI)) begin
				univ_n[15:8] = packet_byte;
			end else if (pos_q == POS_W'(artdmx_pkg::POS_LEN_HI)) begin
				len_n[15:8] = packet_byte;
			end else if (pos_q == POS_W'(artdmx_pkg::POS_LEN_LO)) begin
				len_n[7:0] = packet_byte;
			end else if (16'(pos_q) >= data_first && dmx_for_us && room) begin
				result.write_enable  = 1'b1;
				result.channel_index = cw_q;
				result.channel_value = packet_byte;
				cw_n = cw_q + 1'b1;
			end
			pos_n = pos_q + 1'b1;
		end
		if (last_byte) begin
			result.packet_done = 1'b1;
			if (!id_ok_n || pos_q < POS_W'(artdmx_pkg::ID_MIN_LAST)) begin
				result.packet_status = artdmx_pkg::ST_BAD_ID;
			end else if (opc_n == artdmx_pkg::OP_POLL) begin
				result.packet_status = artdmx_pkg::ST_POLL;
			end else if (opc_n != artdmx_pkg::OP_DMX) begin
				result.packet_status = artdmx_pkg::ST_OTHER_OP;
			end else if (univ_n[artdmx_pkg::UNIV_W-1:0] != universe) begin
				result.packet_status = artdmx_pkg::ST_UNIV_MISMATCH;
			end else begin
				result.packet_status = artdmx_pkg::ST_DMX_APPLIED;
			end
			pos_n   = '0;
			id_ok_n = 1'b1;
			opc_n   = '0;
			univ_n  = '0;
			len_n   = '0;
			cw_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			id_ok_q <= 1'b1;
			opc_q   <= '0;
			univ_q  <= '0;
			len_q   <= '0;
			cw_q    <= '0;
		end else if (advance) begin
			pos_q   <= pos_n;
			id_ok_q <= id_ok_n;
			opc_q   <= opc_n;
			univ_q  <= univ_n;
			len_q   <= len_n;
			cw_q    <= cw_n;
		end
	end

endmodule
